FILE: rtl/assert_macros.svh
// Assertion macros shared by the region-size RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

FILE: rtl/lcr_pkg.sv
// Shared types, constants and neighbor tables of the largest-region block.
package lcr_pkg;

   localparam int CFG_W = 7;
   localparam int RSP_W = 13;
   localparam logic [RSP_W-1:0] OUT_MAX = 13'd8191;

   // Configuration register indexes.
   localparam logic REG_ROW_COUNT    = 1'b0;
   localparam logic REG_COLUMN_COUNT = 1'b1;

   localparam logic [2:0] NB_LAST = 3'd7;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SCAN_CHK,
      S_POP,
      S_NB,
      S_NB_CHK
   } lcr_state_type;

   typedef struct packed {
      logic load;
      logic scan_rd;
      logic scan_next;
      logic push_scan;
      logic close;
      logic pop;
      logic nb_rd;
      logic nb_next;
      logic push_nb;
      logic finish;
   } lcr_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic grid_hit;
      logic stack_empty;
      logic nb_inside;
      logic nb_last;
   } lcr_stat_type;

   // Row step of the eight neighbors, skipping the center cell.
   function automatic logic signed [1:0] nb_row_step(input logic [2:0] k);
      case (k)
         3'd0, 3'd1, 3'd2: nb_row_step = -2'sd1;
         3'd3, 3'd4:       nb_row_step = 2'sd0;
         default:          nb_row_step = 2'sd1;
      endcase
   endfunction

   function automatic logic signed [1:0] nb_col_step(input logic [2:0] k);
      case (k)
         3'd0, 3'd3, 3'd5: nb_col_step = -2'sd1;
         3'd1, 3'd6:       nb_col_step = 2'sd0;
         default:          nb_col_step = 2'sd1;
      endcase
   endfunction

endpackage

FILE: rtl/largest_connected_region_size.sv
// Top level of the largest 8-connected region size block.
//
// Use: write row_count (index 0) and column_count (index 1) on the csr_ port
// while the block is idle; each write takes effect at once. Then send grid
// cells in row-major order, one word per cycle, by raising start with
// req_cell_set while busy is low. Cells past rows*cols are dropped; cells
// never sent count as empty.
// A word with req_last_cell set starts the walk: busy rises in the next
// cycle and stays high until the result is ready. The walk reads and then
// checks each cell in scan order, pops each stacked cell, and reads and
// checks each neighbor that lies inside the grid, pushing the filled ones.
// rsp_strobe is then high for exactly one cycle with rsp_largest_region, in
// the cycle that busy is low again.
// The receiver cannot stall; the result must be taken when strobed.
// Reset clears all control state and sets both dimensions to their maximum;
// no clearing pass is needed, as a fill count marks which grid cells hold
// data.
module largest_connected_region_size #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_cell_set,
   input  logic                      req_last_cell,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [lcr_pkg::CFG_W-1:0] csr_write_data,
   output logic                      rsp_strobe,
   output logic [lcr_pkg::RSP_W-1:0] rsp_largest_region
);
   import lcr_pkg::*;

   lcr_cmd_type  cmd;
   lcr_stat_type stat;

   lcr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_last_cell (req_last_cell),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   lcr_datapath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_cell_set       (req_cell_set),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_strobe         (rsp_strobe),
      .rsp_largest_region (rsp_largest_region)
   );

endmodule

FILE: rtl/lcr_datapath.sv
// Datapath of the region-size block: grid memory, walk stack, counters.
`include "assert_macros.svh"

module lcr_datapath #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_cell_set,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [lcr_pkg::CFG_W-1:0]     csr_write_data,
   input  lcr_pkg::lcr_cmd_type          cmd,
   output lcr_pkg::lcr_stat_type         stat,
   output logic                          rsp_strobe,
   output logic [lcr_pkg::RSP_W-1:0]     rsp_largest_region
);
   import lcr_pkg::*;

   localparam int CELL_CAP = MAX_ROWS * MAX_COLS;
   localparam int IDX_W    = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
   localparam int POS_W    = $clog2(CELL_CAP + 1);
   localparam int R_W      = $clog2(MAX_ROWS + 1);
   localparam int C_W      = $clog2(MAX_COLS + 1);
   localparam int RR_W     = (R_W > CFG_W) ? R_W : CFG_W;
   localparam int CC_W     = (C_W > CFG_W) ? C_W : CFG_W;
   localparam int ENT_W    = IDX_W + R_W + C_W;
   localparam int SW       = POS_W + 2;

   // Configuration registers.
   logic [RR_W-1:0] row_cfg_ff, row_cfg_in;
   logic [CC_W-1:0] col_cfg_ff, col_cfg_in;

   // Control registers.
   logic [POS_W-1:0] load_pos_ff, load_pos_in;
   logic [POS_W-1:0] scan_idx_ff, scan_idx_in;
   logic [R_W-1:0]   scan_r_ff, scan_r_in;
   logic [C_W-1:0]   scan_c_ff, scan_c_in;
   logic [POS_W-1:0] sp_ff, sp_in;
   logic [POS_W-1:0] region_ff, region_in;
   logic [POS_W-1:0] best_ff, best_in;
   logic [2:0]       nb_k_ff, nb_k_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   // Payload registers.
   logic [POS_W-1:0] nb_pos_ff, nb_pos_in;
   logic [R_W-1:0]   nb_r_ff, nb_r_in;
   logic [C_W-1:0]   nb_c_ff, nb_c_in;
   logic [POS_W-1:0] rd_pos_ff, rd_pos_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // Memories.
   logic             grid_mem [CELL_CAP];
   logic [ENT_W-1:0] stack_mem [CELL_CAP];
   logic             grid_rd_ff;
   logic [ENT_W-1:0] stk_rd_ff;

   logic             grid_we, grid_re, grid_wdata;
   logic [IDX_W-1:0] grid_waddr, grid_raddr;
   logic             stk_we, stk_re;
   logic [IDX_W-1:0] stk_waddr, stk_raddr;
   logic [ENT_W-1:0] stk_wdata;

   logic [R_W-1:0]   rows;
   logic [C_W-1:0]   cols;
   logic [POS_W-1:0] total;
   logic [POS_W-1:0] sp_dec;

   logic [IDX_W-1:0]     cur_idx;
   logic [R_W-1:0]       cur_r;
   logic [C_W-1:0]       cur_c;
   logic signed [1:0]    dr, dc;
   logic signed [R_W+1:0] nr_s;
   logic signed [C_W+1:0] nc_s;
   logic signed [SW-1:0]  row_off, n_s;
   logic                 inside_r, inside_c;

   // Effective dimensions: zero reads as one, oversize clamps to the maximum.
   always_comb begin
      if (row_cfg_ff == '0) begin
         rows = R_W'(1);
      end else if (32'(row_cfg_ff) > 32'(MAX_ROWS)) begin
         rows = R_W'(MAX_ROWS);
      end else begin
         rows = R_W'(row_cfg_ff);
      end
      if (col_cfg_ff == '0) begin
         cols = C_W'(1);
      end else if (32'(col_cfg_ff) > 32'(MAX_COLS)) begin
         cols = C_W'(MAX_COLS);
      end else begin
         cols = C_W'(col_cfg_ff);
      end
   end

   assign total  = POS_W'(rows) * POS_W'(cols);
   assign sp_dec = sp_ff - POS_W'(1);

   // Neighbor of the cell on top of the walk, taken from the stack read word.
   always_comb begin
      cur_idx  = stk_rd_ff[ENT_W-1 -: IDX_W];
      cur_r    = stk_rd_ff[R_W+C_W-1 -: R_W];
      cur_c    = stk_rd_ff[C_W-1:0];
      dr       = nb_row_step(nb_k_ff);
      dc       = nb_col_step(nb_k_ff);
      nr_s     = $signed({2'b00, cur_r}) + (R_W+2)'(dr);
      nc_s     = $signed({2'b00, cur_c}) + (C_W+2)'(dc);
      inside_r = !nr_s[R_W+1] && (nr_s < $signed({2'b00, rows}));
      inside_c = !nc_s[C_W+1] && (nc_s < $signed({2'b00, cols}));
      if (dr == 2'sd1) begin
         row_off = $signed(SW'(cols));
      end else if (dr == -2'sd1) begin
         row_off = -$signed(SW'(cols));
      end else begin
         row_off = '0;
      end
      n_s = $signed(SW'(cur_idx)) + row_off + SW'(dc);
   end

   always_comb begin
      stat.scan_done   = (scan_idx_ff == total);
      stat.grid_hit    = grid_rd_ff && (rd_pos_ff < load_pos_ff);
      stat.stack_empty = (sp_ff == '0);
      stat.nb_inside   = inside_r && inside_c;
      stat.nb_last     = (nb_k_ff == NB_LAST);
   end

   // Memory port selection.
   always_comb begin
      grid_we    = 1'b0;
      grid_waddr = load_pos_ff[IDX_W-1:0];
      grid_wdata = req_cell_set;
      grid_re    = 1'b0;
      grid_raddr = scan_idx_ff[IDX_W-1:0];
      stk_we     = 1'b0;
      stk_waddr  = sp_ff[IDX_W-1:0];
      stk_wdata  = {scan_idx_ff[IDX_W-1:0], scan_r_ff, scan_c_ff};
      stk_re     = cmd.pop;
      stk_raddr  = sp_dec[IDX_W-1:0];
      if (cmd.load && (load_pos_ff < total)) begin
         grid_we = 1'b1;
      end
      if (cmd.scan_rd) begin
         grid_re = 1'b1;
      end
      if (cmd.nb_rd) begin
         grid_re    = 1'b1;
         grid_raddr = n_s[IDX_W-1:0];
      end
      // A cell is cleared in the grid when pushed; this serves as its visited mark.
      if (cmd.push_scan) begin
         grid_we    = 1'b1;
         grid_waddr = scan_idx_ff[IDX_W-1:0];
         grid_wdata = 1'b0;
         stk_we     = 1'b1;
      end
      if (cmd.push_nb) begin
         grid_we    = 1'b1;
         grid_waddr = nb_pos_ff[IDX_W-1:0];
         grid_wdata = 1'b0;
         stk_we     = 1'b1;
         stk_wdata  = {nb_pos_ff[IDX_W-1:0], nb_r_ff, nb_c_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[grid_waddr] <= grid_wdata;
      end
      if (grid_re) begin
         grid_rd_ff <= grid_mem[grid_raddr];
      end
      if (stk_we) begin
         stack_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stack_mem[stk_raddr];
      end
   end

   // Next values of the registers.
   always_comb begin
      row_cfg_in    = row_cfg_ff;
      col_cfg_in    = col_cfg_ff;
      load_pos_in   = load_pos_ff;
      scan_idx_in   = scan_idx_ff;
      scan_r_in     = scan_r_ff;
      scan_c_in     = scan_c_ff;
      sp_in         = sp_ff;
      region_in     = region_ff;
      best_in       = best_ff;
      nb_k_in       = nb_k_ff;
      nb_pos_in     = nb_pos_ff;
      nb_r_in       = nb_r_ff;
      nb_c_in       = nb_c_ff;
      rd_pos_in     = rd_pos_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_strobe_in = cmd.finish;

      if (csr_write_enable) begin
         case (csr_index)
            REG_ROW_COUNT:    row_cfg_in = RR_W'(csr_write_data);
            REG_COLUMN_COUNT: col_cfg_in = CC_W'(csr_write_data);
            default: ;
         endcase
      end
      if (cmd.load && (load_pos_ff < total)) begin
         load_pos_in = load_pos_ff + POS_W'(1);
      end
      if (cmd.scan_rd) begin
         rd_pos_in = scan_idx_ff;
      end
      if (cmd.nb_rd) begin
         nb_pos_in = n_s[POS_W-1:0];
         nb_r_in   = nr_s[R_W-1:0];
         nb_c_in   = nc_s[C_W-1:0];
         rd_pos_in = n_s[POS_W-1:0];
      end
      if (cmd.push_scan) begin
         sp_in     = sp_ff + POS_W'(1);
         region_in = '0;
      end
      if (cmd.push_nb) begin
         sp_in = sp_ff + POS_W'(1);
      end
      if (cmd.pop) begin
         sp_in     = sp_dec;
         region_in = region_ff + POS_W'(1);
         nb_k_in   = '0;
      end
      if (cmd.nb_next) begin
         nb_k_in = nb_k_ff + 3'd1;
      end
      if (cmd.close && (region_ff > best_ff)) begin
         best_in = region_ff;
      end
      if (cmd.scan_next) begin
         scan_idx_in = scan_idx_ff + POS_W'(1);
         if (scan_c_ff == cols - C_W'(1)) begin
            scan_c_in = '0;
            scan_r_in = scan_r_ff + R_W'(1);
         end else begin
            scan_c_in = scan_c_ff + C_W'(1);
         end
      end
      if (cmd.finish) begin
         if (32'(best_ff) > 32'(OUT_MAX)) begin
            rsp_data_in = OUT_MAX;
         end else begin
            rsp_data_in = RSP_W'(best_ff);
         end
         load_pos_in = '0;
         best_in     = '0;
         scan_idx_in = '0;
         scan_r_in   = '0;
         scan_c_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cfg_ff    <= RR_W'(MAX_ROWS);
         col_cfg_ff    <= CC_W'(MAX_COLS);
         load_pos_ff   <= '0;
         scan_idx_ff   <= '0;
         scan_r_ff     <= '0;
         scan_c_ff     <= '0;
         sp_ff         <= '0;
         region_ff     <= '0;
         best_ff       <= '0;
         nb_k_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         row_cfg_ff    <= row_cfg_in;
         col_cfg_ff    <= col_cfg_in;
         load_pos_ff   <= load_pos_in;
         scan_idx_ff   <= scan_idx_in;
         scan_r_ff     <= scan_r_in;
         scan_c_ff     <= scan_c_in;
         sp_ff         <= sp_in;
         region_ff     <= region_in;
         best_ff       <= best_in;
         nb_k_ff       <= nb_k_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      nb_pos_ff   <= nb_pos_in;
      nb_r_ff     <= nb_r_in;
      nb_c_ff     <= nb_c_in;
      rd_pos_ff   <= rd_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_largest_region = rsp_data_ff;

   `ASSERT_RST(a_strobe_single, clock, reset, rsp_strobe_ff |=> !rsp_strobe_ff)
   `ASSERT_RST(a_stack_bound, clock, reset, 32'(sp_ff) <= 32'(CELL_CAP))
   `ASSERT_RST(a_pop_shrinks, clock, reset, cmd.pop |=> (sp_ff == $past(sp_dec)))

endmodule

FILE: rtl/lcr_ctrl.sv
// Controller state machine of the region-size block.
`include "assert_macros.svh"

module lcr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_last_cell,
   input  lcr_pkg::lcr_stat_type stat,
   output lcr_pkg::lcr_cmd_type  cmd,
   output logic                  busy
);
   import lcr_pkg::*;

   lcr_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start && req_last_cell) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            state_in = stat.scan_done ? S_IDLE : S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            state_in = stat.grid_hit ? S_POP : S_SCAN;
         end
         S_POP: begin
            state_in = stat.stack_empty ? S_SCAN : S_NB;
         end
         S_NB: begin
            if (stat.nb_inside) begin
               state_in = S_NB_CHK;
            end else if (stat.nb_last) begin
               state_in = S_POP;
            end
         end
         S_NB_CHK: begin
            state_in = stat.nb_last ? S_POP : S_NB;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.load = start;
         end
         S_SCAN: begin
            cmd.finish  = stat.scan_done;
            cmd.scan_rd = !stat.scan_done;
         end
         S_SCAN_CHK: begin
            cmd.push_scan = stat.grid_hit;
            cmd.scan_next = !stat.grid_hit;
         end
         S_POP: begin
            // An empty stack closes the region and resumes the scan.
            cmd.close     = stat.stack_empty;
            cmd.scan_next = stat.stack_empty;
            cmd.pop       = !stat.stack_empty;
         end
         S_NB: begin
            cmd.nb_rd   = stat.nb_inside;
            cmd.nb_next = !stat.nb_inside;
         end
         S_NB_CHK: begin
            cmd.push_nb = stat.grid_hit;
            cmd.nb_next = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `ASSERT_RST(a_seed_pushed, clock, reset, (state_ff == S_SCAN_CHK && stat.grid_hit) |=> (state_ff == S_POP && !stat.stack_empty))
   `ASSERT_RST(a_finish_empty, clock, reset, cmd.finish |-> stat.stack_empty)

endmodule
